/* hw/rtl/avd_pkg.sv */
package avd_pkg;

  // Converter scaling: voltage = ((sum * 33 + 511) / 1023) / 4
  localparam int unsigned SampleWidth  = 10;
  localparam int unsigned SumWidth     = 12;
  localparam int unsigned ScaledWidth  = 18;
  localparam int unsigned VoltWidth    = 6;
  localparam int unsigned SegWidth     = 7;
  localparam int unsigned PeriodWidth  = 8;

  localparam logic [ScaledWidth-1:0] ScaleRound = 18'd511;

  // Both divisions fold into one floor division by 4092, done as a
  // multiplication by ceil(2^30 / 4092). This is exact for every
  // scaled value below 2^18.
  localparam int unsigned RecipWidth = 19;
  localparam int unsigned RecipShift = 30;
  localparam logic [RecipWidth-1:0] Recip = 19'd262401;
  localparam int unsigned ProdWidth = ScaledWidth + RecipWidth;

  localparam logic [PeriodWidth-1:0] PeriodReset = 8'd25;

  typedef logic [VoltWidth-1:0] volt_t;
  typedef logic [SegWidth-1:0]  seg_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  // Decimal split of a 6-bit value by a short compare chain.
  function automatic digits_t split_digits(input volt_t v);
    digits_t d;
    logic [3:0] t;
    logic [VoltWidth-1:0] rem;
    if (v >= 6'd60) begin
      t = 4'd6;
    end else if (v >= 6'd50) begin
      t = 4'd5;
    end else if (v >= 6'd40) begin
      t = 4'd4;
    end else if (v >= 6'd30) begin
      t = 4'd3;
    end else if (v >= 6'd20) begin
      t = 4'd2;
    end else if (v >= 6'd10) begin
      t = 4'd1;
    end else begin
      t = 4'd0;
    end
    rem = v - VoltWidth'({t, 3'b000} + {2'b00, t, 1'b0});
    d.tens = t;
    d.units = rem[3:0];
    return d;
  endfunction

  // Standard hex seven-segment table, bit 0 is segment a.
  function automatic seg_t seg_pattern(input logic [3:0] digit);
    seg_t s;
    case (digit)
      4'h0: s = 7'h3F;
      4'h1: s = 7'h06;
      4'h2: s = 7'h5B;
      4'h3: s = 7'h4F;
      4'h4: s = 7'h66;
      4'h5: s = 7'h6D;
      4'h6: s = 7'h7D;
      4'h7: s = 7'h07;
      4'h8: s = 7'h7F;
      4'h9: s = 7'h6F;
      4'hA: s = 7'h77;
      4'hB: s = 7'h7C;
      4'hC: s = 7'h39;
      4'hD: s = 7'h5E;
      4'hE: s = 7'h79;
      4'hF: s = 7'h71;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/avd_scale.sv */
module avd_scale
  import avd_pkg::*;
(
  input  logic [SumWidth-1:0] sum,
  output volt_t               voltage
);

  logic [ScaledWidth-1:0] scaled;
  logic [ProdWidth-1:0]   prod;

  // Multiply by 33 as a shift and add, then add the rounding term.
  assign scaled = ScaledWidth'({sum, 5'b00000}) + ScaledWidth'(sum) + ScaleRound;

  // Floor division by 4092 through the reciprocal.
  assign prod = ProdWidth'(scaled) * ProdWidth'(Recip);
  assign voltage = prod[RecipShift +: VoltWidth];

endmodule

/* hw/rtl/adc_average_voltmeter_display_unit.sv */
// Pipeline: a request passes through one input register, then the result register.
// Throughput: one request per cycle; in_stall rises only when both stages are full
// and the result is stalled.
// Reset (synchronous): both stages empty, tick count and voltage_hold zero,
// tens digit shown first, update_period back to 25.
module adc_average_voltmeter_display_unit
  import avd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [PeriodWidth-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SampleWidth-1:0] sample_0,
  input  logic [SampleWidth-1:0] sample_1,
  input  logic [SampleWidth-1:0] sample_2,
  input  logic [SampleWidth-1:0] sample_3,
  output logic                   out_valid,
  input  logic                   out_stall,
  output seg_t                   segments,
  output logic                   tens_digit_on,
  output volt_t                  held_voltage
);

  logic [PeriodWidth-1:0] update_period;
  logic [PeriodWidth-1:0] tick_count;
  logic [PeriodWidth-1:0] tick_count_next;
  logic [PeriodWidth:0]   tick_inc;
  logic                   show_units;
  volt_t                  voltage_hold;

  logic                   s1_valid;
  logic                   s1_update;
  logic                   s1_show_units;
  logic [SumWidth-1:0]    s1_sum;
  logic [SumWidth-1:0]    sum_in;

  logic                   in_accept;
  logic                   out_ready;
  logic                   s1_adv;
  volt_t                  scaled_volt;
  volt_t                  volt_now;
  digits_t                digits;

  // Handshake control.
  assign out_ready = !out_valid || !out_stall;
  assign s1_adv    = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_accept = in_valid && !in_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      update_period <= PeriodReset;
    end else if (cfg_write) begin
      update_period <= cfg_data;
    end
  end

  // Tick counter wraps once the next count reaches the period.
  assign tick_inc = {1'b0, tick_count} + 9'd1;
  assign tick_count_next = (tick_inc >= {1'b0, update_period}) ? '0
                                                               : tick_inc[PeriodWidth-1:0];

  assign sum_in = SumWidth'(sample_0) + SumWidth'(sample_1)
                + SumWidth'(sample_2) + SumWidth'(sample_3);

  // Input stage: sum the samples and note the per-request sequencing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      tick_count <= '0;
      show_units <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid   <= 1'b1;
        tick_count <= tick_count_next;
        show_units <= !show_units;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sum        <= sum_in;
      s1_update     <= (tick_count == '0);
      s1_show_units <= show_units;
    end
  end

  avd_scale u_scale (
    .sum     (s1_sum),
    .voltage (scaled_volt)
  );

  assign volt_now = s1_update ? scaled_volt : voltage_hold;
  assign digits   = split_digits(volt_now);

  // Result stage and held voltage, both in request order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      voltage_hold <= '0;
    end else begin
      if (s1_adv) begin
        out_valid    <= 1'b1;
        voltage_hold <= volt_now;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      segments      <= seg_pattern(s1_show_units ? digits.units : digits.tens);
      tens_digit_on <= !s1_show_units;
      held_voltage  <= volt_now;
    end
  end

  // A stall on the input only ever comes from a full input stage.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> s1_valid)
    else $error("input stalled with an empty input stage");

  // A request in the input stage with room ahead moves to the result register.
  assert property (@(posedge clk) disable iff (rst) (s1_valid && !out_valid) |=> out_valid)
    else $error("request lost between stages");

  // The held voltage never exceeds 3.3 V.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (held_voltage <= 6'd33))
    else $error("held voltage out of range");

  // Consecutive results alternate between the tens and units displays.
  assert property (@(posedge clk) disable iff (rst)
                   (s1_adv && out_valid && !out_stall) |=> (tens_digit_on != $past(tens_digit_on)))
    else $error("display digits did not alternate");

endmodule
